[hw/rtl/slia_pkg.sv]
package slia_pkg;

   // Field widths of the transfer payloads
   localparam int ADDR_BITS   = 64;
   localparam int COUNT_BITS  = 32;
   localparam int STRIDE_BITS = 16;
   localparam int INDEX_BITS  = 40;
   localparam int FUNC_BITS   = 3;
   localparam int STATUS_BITS = 2;

   // A matching distance never exceeds (count - 1) * stride, so 48 bits
   localparam int DIV_BITS  = COUNT_BITS + STRIDE_BITS;
   // Multiplier: index-sized operand times stride
   localparam int PROD_BITS = INDEX_BITS + STRIDE_BITS;

   // Operation codes
   localparam logic [FUNC_BITS-1:0] FUNC_CLEAR  = 3'd0;
   localparam logic [FUNC_BITS-1:0] FUNC_APPEND = 3'd1;
   localparam logic [FUNC_BITS-1:0] FUNC_I2A    = 3'd2;
   localparam logic [FUNC_BITS-1:0] FUNC_A2I    = 3'd3;
   localparam logic [FUNC_BITS-1:0] FUNC_RANGE  = 3'd4;

   // Status codes
   localparam logic [STATUS_BITS-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL      = 2'd2;

   typedef struct packed {
      logic [FUNC_BITS-1:0]   func;
      logic [ADDR_BITS-1:0]   address_in;
      logic [COUNT_BITS-1:0]  entry_count;
      logic [STRIDE_BITS-1:0] stride;
      logic [INDEX_BITS-1:0]  query_index;
   } req_type;

   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic [ADDR_BITS-1:0]   address_out;
      logic [ADDR_BITS-1:0]   end_address;
      logic [INDEX_BITS-1:0]  index_out;
   } rsp_type;

   // One table row
   typedef struct packed {
      logic [ADDR_BITS-1:0]   base;
      logic [COUNT_BITS-1:0]  count;
      logic [STRIDE_BITS-1:0] stride;
   } seg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_MUL,
      ST_CMP,
      ST_DIV,
      ST_FIN,
      ST_OUT
   } state_type;

endpackage

[hw/rtl/slia_div.sv]
module slia_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [slia_pkg::DIV_BITS-1:0]    dividend,
   input  logic [slia_pkg::STRIDE_BITS-1:0] divisor,
   output logic                             done,
   output logic [slia_pkg::DIV_BITS-1:0]    quotient,
   output logic                             rem_nonzero
);
   import slia_pkg::*;

   localparam int STEP_W = $clog2(DIV_BITS);

   logic                   busy_ff;
   logic                   done_ff;
   logic [STEP_W-1:0]      step_ff;
   logic [DIV_BITS-1:0]    quo_ff;
   logic [STRIDE_BITS-1:0] rem_ff;
   logic [STRIDE_BITS-1:0] dvs_ff;

   logic [STRIDE_BITS:0]   shifted;
   logic [STRIDE_BITS:0]   diff;

   // One restoring step: shift in the next dividend bit, try subtract
   assign shifted = {rem_ff, quo_ff[DIV_BITS-1]};
   assign diff    = shifted - {1'b0, dvs_ff};

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && step_ff == STEP_W'(DIV_BITS - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff  <= dividend;
         rem_ff  <= '0;
         dvs_ff  <= divisor;
         step_ff <= '0;
      end else if (busy_ff) begin
         step_ff <= step_ff + 1'b1;
         if (!diff[STRIDE_BITS]) begin
            rem_ff <= diff[STRIDE_BITS-1:0];
            quo_ff <= {quo_ff[DIV_BITS-2:0], 1'b1};
         end else begin
            rem_ff <= shifted[STRIDE_BITS-1:0];
            quo_ff <= {quo_ff[DIV_BITS-2:0], 1'b0};
         end
      end
   end

   assign done        = done_ff;
   assign quotient    = quo_ff;
   assign rem_nonzero = (rem_ff != '0);

endmodule

[hw/rtl/segment_list_index_address_map.sv]
// Segment list index/address map.
// Request channel (req_valid/req_stall/req_payload) carries one operation:
// clear, append segment, index to address, address to index, or range.
// Response channel (rsp_valid/rsp_stall/rsp_payload) returns exactly one
// result per request, in order, from an output register.
// The block takes one request at a time; req_stall is high while it works.
// Clear, append and rejected lookups go from idle straight to the output
// state, which registers the response once the output register is free.
// Index to address walks the table, reading and evaluating each segment,
// then goes through the shared multiplier and adder.
// Address to index reads, compares, multiplies and span-checks each
// nonempty segment, and on the segment that holds the answer also runs
// the divide step (48 bit-serial steps and a done strobe).
// Range reads the first and last rows.
// The table is a single-port memory; the row walk bounds throughput.
// Reset empties the table (count and total to zero); row contents are not
// cleared and no clearing pass is needed.
// A stalled response holds, and the next request is still taken while it
// waits; a second result then waits in the block until the register frees.
module segment_list_index_address_map #(
   parameter int MAX_SEGMENTS = 64,
   parameter int TOTAL_BITS   = 40
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  slia_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output slia_pkg::rsp_type rsp_payload
);
   import slia_pkg::*;

   localparam int ROW_W  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);
   localparam int ASUM_W = ((TOTAL_BITS > COUNT_BITS) ? TOTAL_BITS : COUNT_BITS) + 1;
   localparam int QCMP_W = (TOTAL_BITS > INDEX_BITS) ? TOTAL_BITS : INDEX_BITS;
   localparam int ISUM_W = ((TOTAL_BITS > DIV_BITS) ? TOTAL_BITS : DIV_BITS) + 1;

   state_type state_ff, state_in;

   logic [CNT_W-1:0]       used_ff;
   logic [TOTAL_BITS-1:0]  total_ff;
   logic [FUNC_BITS-1:0]   op_ff;
   logic [CNT_W-1:0]       ptr_ff;
   logic                   phase_ff;
   logic                   found_ff;
   logic                   divused_ff;
   logic [INDEX_BITS-1:0]  idx_ff;
   logic [ADDR_BITS-1:0]   q_ff;
   logic [TOTAL_BITS-1:0]  seen_ff;
   logic [ADDR_BITS-1:0]   dist_ff;
   logic [ADDR_BITS-1:0]   start_ff;
   logic [INDEX_BITS-1:0]  mula_ff;
   logic [STRIDE_BITS-1:0] mulb_ff;
   logic [PROD_BITS-1:0]   prod_ff;
   rsp_type                res_ff;
   logic                   rsp_valid_ff;
   rsp_type                rsp_ff;

   seg_type                mem [MAX_SEGMENTS];
   seg_type                rd_ff;
   logic                   mem_we;
   logic                   mem_re;

   logic [ASUM_W-1:0]      app_sum;
   logic                   app_ok;
   logic                   i2a_hit;
   logic                   rng_ok;
   logic                   accept;
   logic                   span_hit;
   logic                   out_free;
   rsp_type                res_idle;
   rsp_type                res_fin;
   logic [ISUM_W-1:0]      a2i_sum;

   logic                   div_start;
   logic                   div_done;
   logic [DIV_BITS-1:0]    div_quo;
   logic                   div_rem_nz;

   // Request-time decisions
   assign accept   = (state_ff == ST_IDLE) && req_valid;
   assign app_sum  = ASUM_W'(total_ff) + ASUM_W'(req_payload.entry_count);
   assign app_ok   = (used_ff != CNT_W'(MAX_SEGMENTS)) && (app_sum >> TOTAL_BITS) == '0;
   assign i2a_hit  = QCMP_W'(req_payload.query_index) < QCMP_W'(total_ff);
   assign rng_ok   = (total_ff != '0) && (used_ff != '0);
   assign span_hit = dist_ff <= ADDR_BITS'(prod_ff);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_payload.func == FUNC_A2I ||
                   (req_payload.func == FUNC_I2A && i2a_hit) ||
                   (req_payload.func == FUNC_RANGE && rng_ok)) begin
                  state_in = ST_READ;
               end else begin
                  state_in = ST_OUT;
               end
            end
         end
         ST_READ: begin
            if (op_ff == FUNC_A2I && ptr_ff == used_ff) begin
               state_in = ST_FIN;
            end else begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            case (op_ff)
               FUNC_I2A: begin
                  state_in = (COUNT_BITS'(rd_ff.count) > idx_ff) ? ST_MUL : ST_READ;
               end
               FUNC_A2I: begin
                  if (rd_ff.count == '0) begin
                     state_in = ST_READ;
                  end else if (rd_ff.base >= q_ff) begin
                     state_in = ST_FIN;
                  end else begin
                     state_in = ST_MUL;
                  end
               end
               FUNC_RANGE: begin
                  state_in = phase_ff ? ST_MUL : ST_READ;
               end
               default: begin
                  state_in = ST_OUT;
               end
            endcase
         end
         ST_MUL:  state_in = (op_ff == FUNC_A2I) ? ST_CMP : ST_FIN;
         ST_CMP:  state_in = span_hit ? ST_DIV : ST_READ;
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN:  state_in = ST_OUT;
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control outputs
   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      mem_re    = (state_ff == ST_READ);
      mem_we    = accept && req_payload.func == FUNC_APPEND && app_ok;
      div_start = (state_ff == ST_CMP) && span_hit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Table bookkeeping
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff  <= '0;
         total_ff <= '0;
      end else if (accept) begin
         if (req_payload.func == FUNC_CLEAR) begin
            used_ff  <= '0;
            total_ff <= '0;
         end else if (mem_we) begin
            used_ff  <= used_ff + 1'b1;
            total_ff <= app_sum[TOTAL_BITS-1:0];
         end
      end
   end

   // Segment table
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[used_ff[ROW_W-1:0]] <= '{base:   req_payload.address_in,
                                     count:  req_payload.entry_count,
                                     stride: req_payload.stride};
      end
      if (mem_re) begin
         rd_ff <= mem[ptr_ff[ROW_W-1:0]];
      end
   end

   // Immediate results
   always_comb begin
      res_idle        = '0;
      res_idle.status = STATUS_NOT_FOUND;
      case (req_payload.func)
         FUNC_CLEAR:  res_idle.status = STATUS_OK;
         FUNC_APPEND: res_idle.status = app_ok ? STATUS_OK : STATUS_FULL;
         default:     res_idle.status = STATUS_NOT_FOUND;
      endcase
   end

   // Final results after the walk
   assign a2i_sum = ISUM_W'(seen_ff) +
                    (divused_ff ? ISUM_W'(div_quo) + ISUM_W'(div_rem_nz) : '0);

   always_comb begin
      res_fin = '0;
      case (op_ff)
         FUNC_I2A: begin
            res_fin.status      = STATUS_OK;
            res_fin.address_out = rd_ff.base + ADDR_BITS'(prod_ff);
         end
         FUNC_A2I: begin
            res_fin.status    = found_ff ? STATUS_OK : STATUS_NOT_FOUND;
            res_fin.index_out = a2i_sum[INDEX_BITS-1:0];
         end
         FUNC_RANGE: begin
            res_fin.status      = STATUS_OK;
            res_fin.address_out = start_ff;
            res_fin.end_address = rd_ff.base + ADDR_BITS'(prod_ff);
         end
         default: res_fin.status = STATUS_NOT_FOUND;
      endcase
   end

   // Walk datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_ff      <= req_payload.func;
               ptr_ff     <= '0;
               phase_ff   <= 1'b0;
               found_ff   <= 1'b0;
               divused_ff <= 1'b0;
               idx_ff     <= req_payload.query_index;
               q_ff       <= req_payload.address_in;
               seen_ff    <= '0;
               res_ff     <= res_idle;
            end
         end
         ST_EVAL: begin
            case (op_ff)
               FUNC_I2A: begin
                  if (COUNT_BITS'(rd_ff.count) > idx_ff) begin
                     mula_ff <= idx_ff;
                     mulb_ff <= rd_ff.stride;
                  end else begin
                     idx_ff <= idx_ff - INDEX_BITS'(rd_ff.count);
                     ptr_ff <= ptr_ff + 1'b1;
                  end
               end
               FUNC_A2I: begin
                  if (rd_ff.count == '0) begin
                     ptr_ff <= ptr_ff + 1'b1;
                  end else if (rd_ff.base >= q_ff) begin
                     found_ff <= 1'b1;
                  end else begin
                     dist_ff <= q_ff - rd_ff.base;
                     mula_ff <= INDEX_BITS'(rd_ff.count - 1'b1);
                     mulb_ff <= rd_ff.stride;
                  end
               end
               FUNC_RANGE: begin
                  if (!phase_ff) begin
                     start_ff <= rd_ff.base;
                     phase_ff <= 1'b1;
                     ptr_ff   <= used_ff - 1'b1;
                  end else begin
                     mula_ff <= INDEX_BITS'(rd_ff.count);
                     mulb_ff <= rd_ff.stride;
                  end
               end
               default: begin
                  phase_ff <= phase_ff;
               end
            endcase
         end
         ST_MUL: begin
            prod_ff <= mula_ff * mulb_ff;
         end
         ST_CMP: begin
            if (span_hit) begin
               found_ff   <= 1'b1;
               divused_ff <= 1'b1;
            end else begin
               seen_ff <= seen_ff + TOTAL_BITS'(rd_ff.count);
               ptr_ff  <= ptr_ff + 1'b1;
            end
         end
         ST_FIN: begin
            res_ff <= res_fin;
         end
         default: begin
            op_ff <= op_ff;
         end
      endcase
   end

   // Ceiling divide of the distance by the stride
   slia_div u_div (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .dividend    (dist_ff[DIV_BITS-1:0]),
      .divisor     (rd_ff.stride),
      .done        (div_done),
      .quotient    (div_quo),
      .rem_nonzero (div_rem_nz)
   );

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_OUT && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_OUT && out_free) begin
         rsp_ff <= res_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Checks
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CNT_W'(MAX_SEGMENTS))
      else $error("segment count beyond table depth");

   a_empty_total: assert property (@(posedge clock) disable iff (reset)
      used_ff == '0 |-> total_ff == '0)
      else $error("empty table with nonzero total");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |-> ptr_ff <= used_ff)
      else $error("walk ran past the last segment");

   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("divider finished outside the divide step");

endmodule

[verif/tb_segment_list_index_address_map.sv]
module tb_segment_list_index_address_map;
   import slia_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_ROWS = 64;
   localparam int TOTAL_W    = 40;
   localparam int CYCLE_LIMIT = 2000000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_payload;

   segment_list_index_address_map uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the segment table
   logic [63:0] shadow_base [TABLE_ROWS];
   logic [31:0] shadow_count [TABLE_ROWS];
   logic [15:0] shadow_stride [TABLE_ROWS];
   int unsigned shadow_used = 0;
   logic [63:0] shadow_total = '0;

   rsp_type pending_results[$];
   int      error_count = 0;
   longint  cycle_count = 0;
   int      send_idle_pct = 0;
   int      recv_idle_pct = 0;

   // Directed table; expected result typed in only where obvious
   typedef struct {
      req_type req;
      bit      has_fixed;
      rsp_type fixed;
   } step_row;

   step_row plan_rows[$];

   // Queue one expected result
   function automatic void add_expected(input rsp_type e);
      pending_results.insert(pending_results.size(), e);
   endfunction

   // Queue one directed row
   function automatic void add_row(input req_type r, input bit f, input rsp_type e);
      step_row x;
      x.req = r;
      x.has_fixed = f;
      x.fixed = e;
      plan_rows.insert(plan_rows.size(), x);
   endfunction

   // Lower bound of the flat index whose address reaches the query
   function automatic logic [63:0] find_index(input logic [63:0] q, output bit hit);
      logic [63:0] seen;
      logic [63:0] gap, span, cnt, str;
      seen = '0;
      hit = 1'b0;
      for (int s = 0; s < shadow_used; s++) begin
         cnt = shadow_count[s];
         str = shadow_stride[s];
         if (cnt != 0) begin
            if (shadow_base[s] >= q) begin
               hit = 1'b1;
               return seen;
            end
            gap = q - shadow_base[s];
            span = (cnt - 1) * str;
            if (gap <= span) begin
               hit = 1'b1;
               return seen + (gap + str - 1) / str;
            end
         end
         seen += cnt;
      end
      return seen;
   endfunction

   // Update the shadow table and work out the one result of a transfer
   function automatic rsp_type map_operation(input req_type r);
      rsp_type     res;
      logic [63:0] idx, sum;
      bit          hit;
      res = '0;
      case (r.func)
         FUNC_CLEAR: begin
            shadow_used = 0;
            shadow_total = '0;
         end
         FUNC_APPEND: begin
            sum = shadow_total + r.entry_count;
            if (shadow_used >= TABLE_ROWS || sum >= (64'd1 << TOTAL_W)) begin
               res.status = STATUS_FULL;
            end else begin
               shadow_base[shadow_used] = r.address_in;
               shadow_count[shadow_used] = r.entry_count;
               shadow_stride[shadow_used] = r.stride;
               shadow_used++;
               shadow_total = sum;
            end
         end
         FUNC_I2A: begin
            idx = r.query_index;
            res.status = STATUS_NOT_FOUND;
            if (idx < shadow_total) begin
               for (int s = 0; s < shadow_used; s++) begin
                  if (shadow_count[s] > idx) begin
                     res.address_out = shadow_base[s] + shadow_stride[s] * idx;
                     res.status = STATUS_OK;
                     break;
                  end
                  idx -= shadow_count[s];
               end
            end
         end
         FUNC_A2I: begin
            idx = find_index(r.address_in, hit);
            res.index_out = idx[39:0];
            res.status = hit ? STATUS_OK : STATUS_NOT_FOUND;
         end
         FUNC_RANGE: begin
            if (shadow_total == 0 || shadow_used == 0) begin
               res.status = STATUS_NOT_FOUND;
            end else begin
               res.address_out = shadow_base[0];
               res.end_address = shadow_base[shadow_used-1] +
                  64'(shadow_count[shadow_used-1]) * 64'(shadow_stride[shadow_used-1]);
            end
         end
         default: res.status = STATUS_NOT_FOUND;
      endcase
      return res;
   endfunction

   // Timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Result checking
   always @(posedge clock) begin
      rsp_type exp_res;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result %h", $time, rsp_payload);
            error_count++;
         end else begin
            exp_res = pending_results.pop_front();
            if (rsp_payload.status !== exp_res.status)
               $display("%0t: status exp %h got %h", $time, exp_res.status,
                        rsp_payload.status);
            if (rsp_payload.address_out !== exp_res.address_out)
               $display("%0t: address_out exp %h got %h", $time,
                        exp_res.address_out, rsp_payload.address_out);
            if (rsp_payload.end_address !== exp_res.end_address)
               $display("%0t: end_address exp %h got %h", $time,
                        exp_res.end_address, rsp_payload.end_address);
            if (rsp_payload.index_out !== exp_res.index_out)
               $display("%0t: index_out exp %h got %h", $time,
                        exp_res.index_out, rsp_payload.index_out);
            if (rsp_payload !== exp_res) error_count++;
         end
      end
   end

   // Receiver stall, changed at the falling edge
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // Present one transfer and wait until the rising edge that takes it;
   // valid stays up until the next transfer or an explicit drop
   task automatic drive_transfer(input req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_payload <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   // Send one transfer checked against the predictor
   task automatic send_request(input req_type r);
      drive_transfer(r);
      add_expected(map_operation(r));
      @(negedge clock);
   endtask

   function automatic req_type mk(input logic [2:0] f, input logic [63:0] a,
                                  input logic [31:0] c, input logic [15:0] s,
                                  input logic [39:0] q);
      req_type r;
      r.func = f; r.address_in = a; r.entry_count = c; r.stride = s; r.query_index = q;
      return r;
   endfunction

   function automatic rsp_type st(input logic [1:0] s);
      rsp_type r;
      r = '0;
      r.status = s;
      return r;
   endfunction

   // Random transfer, mostly appends and lookups into a live table
   function automatic req_type random_request();
      req_type r;
      int      pick;
      r.address_in = {$urandom, $urandom};
      r.entry_count = $urandom;
      r.stride = $urandom;
      r.query_index = {$urandom, $urandom};
      pick = $urandom_range(99);
      if (pick < 3) r.func = FUNC_CLEAR;
      else if (pick < 28) r.func = FUNC_APPEND;
      else if (pick < 55) r.func = FUNC_I2A;
      else if (pick < 85) r.func = FUNC_A2I;
      else if (pick < 95) r.func = FUNC_RANGE;
      else r.func = 3'($urandom_range(7, 5));
      if ($urandom_range(3) != 0) r.entry_count = $urandom_range(300);
      if ($urandom_range(3) == 0) r.stride = $urandom_range(3);
      if ($urandom_range(3) != 0 && shadow_total != 0)
         r.query_index = 40'({$urandom, $urandom} % (shadow_total + 2));
      if (r.func == FUNC_A2I && shadow_used != 0 && $urandom_range(3) != 0)
         r.address_in = shadow_base[$urandom_range(shadow_used - 1)] +
                        64'($urandom_range(2000));
      return r;
   endfunction

   initial begin
      step_row row;
      rsp_type got;
      int      idle_wait;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      add_row(mk(FUNC_RANGE, '1, '1, '1, '1), 1, st(STATUS_NOT_FOUND));
      add_row(mk(FUNC_I2A, 0, 0, 0, 0), 1, st(STATUS_NOT_FOUND));
      add_row(mk(FUNC_A2I, 0, 0, 0, 0), 1, st(STATUS_NOT_FOUND));
      add_row(mk(3'd5, '1, '1, '1, '1), 1, st(STATUS_NOT_FOUND));
      add_row(mk(3'd7, '1, '1, '1, '1), 1, st(STATUS_NOT_FOUND));
      add_row(mk(FUNC_APPEND, '1, '1, '1, '1), 1, st(STATUS_OK));
      add_row(mk(FUNC_APPEND, 64'h10, 0, 16'h8, 0), 1, st(STATUS_OK));
      add_row(mk(FUNC_RANGE, 0, 0, 0, 0), 0, '0);
      add_row(mk(FUNC_I2A, 0, 0, 0, 40'hFFFF_FFFE), 0, '0);
      add_row(mk(FUNC_I2A, 0, 0, 0, '1), 1, st(STATUS_NOT_FOUND));
      add_row(mk(FUNC_A2I, '1, 0, 0, 0), 0, '0);
      add_row(mk(FUNC_A2I, 64'h0, 0, 0, 0), 0, '0);
      add_row(mk(FUNC_APPEND, 64'h1000, '1, 0, 0), 0, '0);
      add_row(mk(FUNC_A2I, 64'h1000, 0, 0, 0), 0, '0);
      add_row(mk(FUNC_I2A, 0, 0, 0, 40'h1_2345_6789), 0, '0);
      add_row(mk(FUNC_APPEND, 0, 32'd10, 16'd4, 0), 0, '0);
      add_row(mk(FUNC_CLEAR, '1, '1, '1, '1), 1, st(STATUS_OK));
      add_row(mk(FUNC_RANGE, 0, 0, 0, 0), 1, st(STATUS_NOT_FOUND));
      add_row(mk(FUNC_APPEND, 64'h100, 32'd5, 16'd3, 0), 1, st(STATUS_OK));
      add_row(mk(FUNC_A2I, 64'h105, 0, 0, 0), 0, '0);
      add_row(mk(FUNC_A2I, 64'h200, 0, 0, 0), 0, '0);
      // Fill the table to its limit, then one more is rejected
      for (int i = 1; i < TABLE_ROWS; i++)
         add_row(mk(FUNC_APPEND, 64'h1000 * i, 32'd2, 16'd8, 0), 0, '0);
      add_row(mk(FUNC_APPEND, 0, 1, 1, 0), 1, st(STATUS_FULL));
      add_row(mk(FUNC_I2A, 0, 0, 0, 40'd130), 0, '0);
      add_row(mk(FUNC_A2I, 64'h3F001, 0, 0, 0), 0, '0);
      add_row(mk(FUNC_CLEAR, 0, 0, 0, 0), 1, st(STATUS_OK));

      foreach (plan_rows[i]) begin
         row = plan_rows[i];
         if (row.has_fixed) begin
            // The shadow table still has to follow the fixed rows
            got = map_operation(row.req);
            if (got !== row.fixed)
               $display("%0t: table row %0d exp %h got %h", $time, i, row.fixed, got);
            if (got !== row.fixed) error_count++;
            drive_transfer(row.req);
            add_expected(row.fixed);
            @(negedge clock);
         end else begin
            send_request(row.req);
         end
      end
      req_valid <= 1'b0;

      // Sender pauses until every result has come
      while (pending_results.size() != 0) @(negedge clock);

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 38 : (phase == 1) ? 51 : 0;
         recv_idle_pct = (phase == 0) ? 51 : (phase == 1) ? 38 : 0;
         for (int n = 0; n < 470; n++) send_request(random_request());
      end
      req_valid <= 1'b0;

      idle_wait = 0;
      while (pending_results.size() != 0 && idle_wait < 100000) begin
         @(negedge clock);
         idle_wait++;
      end
      repeat (400) @(negedge clock);
      if (error_count == 0 && pending_results.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end
endmodule
